@@ hdl/ffkc_pkg.sv @@
// Package for the farthest-first k-center block.
// Payload structs, function and register codes, state type. No dependencies.
`default_nettype none

package ffkc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRY_ALL      = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  localparam logic [8:0] VERTEX_COUNT_RST = 9'd256;
  localparam logic [6:0] CENTER_COUNT_RST = 7'd2;

  typedef struct packed {
    logic        func;
    logic [7:0]  row_vertex;
    logic [7:0]  col_vertex;
    logic [31:0] entry_distance;
    logic [7:0]  start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  center_position;
    logic [7:0]  center_vertex;
    logic [31:0] radius;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_STEP
  } ffkc_state_t;

endpackage

`default_nettype wire

@@ hdl/ffkc_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/farthest_first_k_center_top.sv @@
// Farthest-first k-center selection over a stored distance matrix.
// Matrix write transaction: one per cycle while idle (in_stall is high during a run). A run walks
// the store column by column: each pass reads one column over n vertices, a single-start run
// takes k passes and a try-all run n*k passes; the distance RAM port sets the pass length.
// Reset (synchronous, rst_n low) clears control, sets n=256, k=2, single-start; the distance
// store is undefined until written and is never cleared.
`default_nettype none

module farthest_first_k_center_top
  import ffkc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_CENTERS  = 64,
  parameter int DIST_BITS    = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int VCW  = $clog2(MAX_VERTICES + 1);
  localparam int NCW  = (VCW > 9) ? VCW : 9;
  localparam int AW   = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int KW   = $clog2(MAX_CENTERS + 1);
  localparam int PW   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

  // configuration
  logic [8:0] vcount_r;
  logic [6:0] ccount_r;
  logic       try_cfg_r;

  // control
  ffkc_state_t          state_r, state_nxt;
  logic [VCW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]        daddr_r, daddr_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [VW-1:0]        rd_j_r, rd_j_nxt;
  logic                 first_r, first_nxt;
  logic [DIST_BITS-1:0] far_d_r, far_d_nxt;
  logic [VW-1:0]        far_v_r, far_v_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [VW-1:0]        cur_c_r, cur_c_nxt;
  logic [VW-1:0]        start_r, start_nxt;
  logic                 try_r, try_nxt;
  logic [DIST_BITS-1:0] best_r, best_nxt;
  logic [VCW-1:0]       n_r, n_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 launch;
  logic [VW-1:0]        launch_c;
  logic                 launch_first;

  logic                 in_acc;
  logic                 row_ok, col_ok;
  logic                 dist_we;
  logic [AW-1:0]        dist_waddr;
  logic [DIST_BITS-1:0] dist_q, near_q, new_d, best_min;
  logic                 near_we;

  logic [NCW-1:0]       vc_ext, n_wide, sv_wide, s_wide;
  logic [6:0]           k_wide;
  logic                 last_pos, last_start, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // matrix writes
  assign row_ok     = 32'(in_data.row_vertex) < MAX_VERTICES;
  assign col_ok     = 32'(in_data.col_vertex) < MAX_VERTICES;
  assign dist_we    = in_acc && (in_data.func == FUNC_WRITE) && row_ok && col_ok;
  assign dist_waddr = AW'(32'(in_data.row_vertex) * MAX_VERTICES + 32'(in_data.col_vertex));

  ffkc_ram #(
    .WIDTH(DIST_BITS),
    .DEPTH(MAX_VERTICES * MAX_VERTICES)
  ) u_dist_ram (
    .clk    (clk),
    .wr_en  (dist_we),
    .wr_addr(dist_waddr),
    .wr_data(DIST_BITS'(in_data.entry_distance)),
    .rd_addr(daddr_r),
    .rd_data(dist_q)
  );

  assign new_d   = first_r ? dist_q : ((dist_q < near_q) ? dist_q : near_q);
  assign near_we = (state_r == ST_PASS) && rd_v_r;

  ffkc_ram #(
    .WIDTH(DIST_BITS),
    .DEPTH(MAX_VERTICES)
  ) u_near_ram (
    .clk    (clk),
    .wr_en  (near_we),
    .wr_addr(rd_j_r),
    .wr_data(new_d),
    .rd_addr(cnt_r[VW-1:0]),
    .rd_data(near_q)
  );

  // effective run sizes
  always_comb begin
    vc_ext = NCW'(vcount_r);
    if (vc_ext == '0) begin
      n_wide = NCW'(1);
    end else if (vc_ext > NCW'(MAX_VERTICES)) begin
      n_wide = NCW'(MAX_VERTICES);
    end else begin
      n_wide = vc_ext;
    end
    if (ccount_r == '0) begin
      k_wide = 7'd1;
    end else if (32'(ccount_r) > MAX_CENTERS) begin
      k_wide = 7'(MAX_CENTERS);
    end else begin
      k_wide = ccount_r;
    end
    sv_wide = NCW'(in_data.start_vertex);
    s_wide  = (sv_wide >= n_wide) ? (n_wide - NCW'(1)) : sv_wide;
  end

  assign last_pos   = (KW'(pos_r) + KW'(1)) == k_r;
  assign last_start = (VCW'(start_r) + VCW'(1)) == n_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign best_min   = (far_d_r < best_r) ? far_d_r : best_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    daddr_nxt     = daddr_r;
    rd_v_nxt      = 1'b0;
    rd_j_nxt      = rd_j_r;
    first_nxt     = first_r;
    far_d_nxt     = far_d_r;
    far_v_nxt     = far_v_r;
    pos_nxt       = pos_r;
    cur_c_nxt     = cur_c_r;
    start_nxt     = start_r;
    try_nxt       = try_r;
    best_nxt      = best_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    launch        = 1'b0;
    launch_c      = cur_c_r;
    launch_first  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.func == FUNC_RUN)) begin
          n_nxt        = n_wide[VCW-1:0];
          k_nxt        = KW'(k_wide);
          try_nxt      = try_cfg_r;
          best_nxt     = DIST_INF;
          pos_nxt      = '0;
          start_nxt    = '0;
          launch       = 1'b1;
          launch_first = 1'b1;
          launch_c     = try_cfg_r ? '0 : VW'(s_wide);
        end
      end
      ST_PASS: begin
        if (cnt_r < n_r) begin
          cnt_nxt   = cnt_r + VCW'(1);
          daddr_nxt = daddr_r + AW'(MAX_VERTICES);
          rd_v_nxt  = 1'b1;
          rd_j_nxt  = cnt_r[VW-1:0];
        end
        if (rd_v_r && (new_d > far_d_r)) begin
          far_d_nxt = new_d;
          far_v_nxt = rd_j_r;
        end
        if (cnt_r == n_r) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!try_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.center_position = 6'(pos_r);
            out_data_nxt.center_vertex   = 8'(cur_c_r);
            out_data_nxt.radius          = last_pos ? 32'(far_d_r) : 32'd0;
            out_data_nxt.last            = last_pos;
            if (last_pos) begin
              state_nxt = ST_IDLE;
            end else begin
              pos_nxt  = pos_r + PW'(1);
              launch   = 1'b1;
              launch_c = far_v_r;
            end
          end
        end else if (!last_pos) begin
          pos_nxt  = pos_r + PW'(1);
          launch   = 1'b1;
          launch_c = far_v_r;
        end else if (last_start) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.center_position = '0;
            out_data_nxt.center_vertex   = '0;
            out_data_nxt.radius          = 32'(best_min);
            out_data_nxt.last            = 1'b1;
            best_nxt  = best_min;
            state_nxt = ST_IDLE;
          end
        end else begin
          best_nxt     = best_min;
          start_nxt    = start_r + VW'(1);
          pos_nxt      = '0;
          launch       = 1'b1;
          launch_first = 1'b1;
          launch_c     = start_r + VW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (launch) begin
      state_nxt = ST_PASS;
      cnt_nxt   = '0;
      daddr_nxt = AW'(launch_c);
      first_nxt = launch_first;
      far_d_nxt = '0;
      far_v_nxt = launch_c;
      cur_c_nxt = launch_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r  <= VERTEX_COUNT_RST;
      ccount_r  <= CENTER_COUNT_RST;
      try_cfg_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r  <= cfg_wdata;
        CFG_CENTER_COUNT: ccount_r  <= cfg_wdata[6:0];
        CFG_TRY_ALL:      try_cfg_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      first_r     <= 1'b0;
      pos_r       <= '0;
      start_r     <= '0;
      try_r       <= 1'b0;
      best_r      <= DIST_INF;
      n_r         <= VCW'(1);
      k_r         <= KW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      first_r     <= first_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      try_r       <= try_nxt;
      best_r      <= best_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    daddr_r    <= daddr_nxt;
    rd_j_r     <= rd_j_nxt;
    far_d_r    <= far_d_nxt;
    far_v_r    <= far_v_nxt;
    cur_c_r    <= cur_c_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no read may still be in flight when the pass result is used
  a_step_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> !rd_v_r)
    else $error("read pending in step state");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS) |-> (cnt_r <= n_r))
    else $error("pass issued beyond vertex count");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (KW'(pos_r) < k_r))
    else $error("centre position beyond k");

  a_far_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS && $past(state_r) == ST_PASS) |-> (far_d_r >= $past(far_d_r)))
    else $error("farthest distance fell within a pass");

endmodule

`default_nettype wire
